### design/hvlp_pkg.sv
package hvlp_pkg;

    localparam int LineBufferBytes = 64;
    localparam int NameCount       = 8;

    // Message kinds
    typedef enum logic [2:0] {
        KIND_HELLO  = 3'd0,
        KIND_PID    = 3'd1,
        KIND_MODE   = 3'd2,
        KIND_HEATER = 3'd3,
        KIND_TEMP_C = 3'd4,
        KIND_TEMP_A = 3'd5,
        KIND_POWER  = 3'd6,
        KIND_NOK    = 3'd7
    } kind_t;

    localparam logic [31:0] FieldCap = 32'h8000_0000;
    localparam logic [20:0] WholeCap = 21'd1048575;

    // Decimal parser flags
    typedef struct packed {
        logic done;
        logic neg;
        logic started;
    } pflags_t;

    // Line end event from the byte front end to the result stage
    typedef struct packed {
        logic        fire;
        logic [7:0]  match;
        logic [5:0]  hlen;
        logic [7:0]  first_byte;
        logic [1:0]  field_index;
        logic [31:0] acc0;
        logic [31:0] acc1;
        logic [31:0] acc2;
        logic        neg0;
        logic        neg1;
        logic        neg2;
        logic [20:0] whole;
        logic        whole_neg;
    } line_evt_t;

    function automatic logic [2:0] name_len(input int k);
        logic [2:0] l;
        unique case (k)
            0: l = 3'd5;
            1: l = 3'd3;
            2: l = 3'd1;
            7: l = 3'd3;
            default: l = 3'd2;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] name_char(input int k, input logic [5:0] pos);
        logic [39:0] s;
        logic [7:0]  c;
        unique case (k)
            0: s = "OLLEH";
            1: s = {16'h0, "DIP"};
            2: s = {32'h0, "M"};
            3: s = {24'h0, "SH"};
            4: s = {24'h0, "CT"};
            5: s = {24'h0, "AT"};
            6: s = {24'h0, "WP"};
            default: s = {16'h0, "KON"};
        endcase
        c = 8'h00;
        if (pos < 6'd5)
        begin
            c = s[pos[2:0]*8 +: 8];
        end
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

### design/header_value_line_parser.sv
// A line end byte's result passes through the stage 1 register and the output register.
// Throughput: one byte per cycle; input stalls while both result
// stages hold transactions.
// Reset: rst_n asynchronous, active low; clears parser state and
// valid flags, restarting in header phase.
module header_value_line_parser
    import hvlp_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = LineBufferBytes
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] msg_kind, [3] flag_bit, [35:4] gain_p, [67:36] gain_i,
    // [99:68] gain_d, [119:100] raw_reading, [142:120] scaled_reading, rest 0
    output logic [143:0] m_axis_tdata
);

    line_evt_t   evt;
    logic        take;
    logic        busy;
    logic [2:0]  msg_kind;
    logic        flag_bit;
    logic [31:0] gain_p, gain_i, gain_d;
    logic [19:0] raw_reading;
    logic [22:0] scaled_reading;

    // Stall only when both result stages are full
    assign s_axis_tready = !busy;
    assign take = s_axis_tvalid && s_axis_tready;

    hvlp_front #(.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .c(s_axis_tdata), .evt(evt)
    );

    hvlp_result u_res (
        .clk(clk), .rst_n(rst_n), .evt(evt), .busy(busy),
        .out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
        .msg_kind(msg_kind), .flag_bit(flag_bit),
        .gain_p(gain_p), .gain_i(gain_i), .gain_d(gain_d),
        .raw_reading(raw_reading), .scaled_reading(scaled_reading)
    );

    assign m_axis_tdata = {1'b0, scaled_reading, raw_reading, gain_d, gain_i,
                           gain_p, flag_bit, msg_kind};

    // A PID result never carries a zero proportional gain
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != KIND_PID
                           || m_axis_tdata[35:4] != 32'd0))
        else $error("pid result with zero gain");

    // Output holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

### design/hvlp_dec.sv
module hvlp_dec
    import hvlp_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic [7:0]   c,
    input  pflags_t      flags,
    input  logic [W-1:0] acc,
    input  logic [W-1:0] cap,
    output pflags_t      flags_next,
    output logic [W-1:0] acc_next
);

    logic [W+3:0] prod;
    logic [3:0]   dig;

    assign dig  = c[3:0];
    assign prod = {4'b0, acc} * (W+4)'(10) + (W+4)'(dig);

    // Advance one decimal step
    always_comb
    begin
        flags_next = flags;
        acc_next   = acc;
        if (!flags.done)
        begin
            if (!flags.started)
            begin
                if (is_blank(c))
                begin
                    flags_next = flags;
                end
                else if (c == "+")
                begin
                    flags_next.started = 1'b1;
                end
                else if (c == "-")
                begin
                    flags_next.started = 1'b1;
                    flags_next.neg     = 1'b1;
                end
                else if (is_digit(c))
                begin
                    flags_next.started = 1'b1;
                    acc_next           = W'(dig);
                end
                else
                begin
                    flags_next.done = 1'b1;
                end
            end
            else if (is_digit(c))
            begin
                acc_next = (prod > {4'b0, cap}) ? cap : prod[W-1:0];
            end
            else
            begin
                flags_next.done = 1'b1;
            end
        end
    end

endmodule

### design/hvlp_front.sv
module hvlp_front
    import hvlp_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = LineBufferBytes
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] c,
    output line_evt_t  evt
);

    localparam int PosW = $clog2(LINE_BUFFER_BYTES);

    logic            hdr_reg, hdr_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [7:0]      match_reg, match_next;
    logic [PosW-1:0] hlen_reg, hlen_next;
    logic [7:0]      first_reg, first_next;
    logic            term_reg, term_next;
    logic [1:0]      fidx_reg, fidx_next;
    logic [31:0]     acc_reg [3];
    logic [31:0]     acc_next [3];
    pflags_t         fl_reg [3];
    pflags_t         fl_next [3];
    logic [20:0]     whole_reg, whole_next;
    pflags_t         wfl_reg, wfl_next;

    logic [31:0]     sel_acc, sel_acc_d;
    pflags_t         sel_fl, sel_fl_d;
    logic [20:0]     whole_d;
    pflags_t         wfl_d;
    logic [PosW-1:0] pos_inc;
    logic [PosW-1:0] limit;

    assign limit   = PosW'(LINE_BUFFER_BYTES - 1);
    assign pos_inc = pos_reg + PosW'(1);
    assign sel_acc = acc_reg[fidx_reg];
    assign sel_fl  = fl_reg[fidx_reg];

    hvlp_dec #(.W(32)) u_field (
        .c(c), .flags(sel_fl), .acc(sel_acc), .cap(FieldCap),
        .flags_next(sel_fl_d), .acc_next(sel_acc_d)
    );

    hvlp_dec #(.W(21)) u_whole (
        .c(c), .flags(wfl_reg), .acc(whole_reg), .cap(WholeCap),
        .flags_next(wfl_d), .acc_next(whole_d)
    );

    // Line end event towards the result stage; a surviving match bit
    // implies a header of at most five bytes, so six length bits suffice
    always_comb
    begin
        evt.fire        = take && !hdr_reg && (c == 8'h0A || c == 8'h0D);
        evt.match       = match_reg;
        evt.hlen        = 6'(hlen_reg);
        evt.first_byte  = first_reg;
        evt.field_index = fidx_reg;
        evt.acc0        = acc_reg[0];
        evt.acc1        = acc_reg[1];
        evt.acc2        = acc_reg[2];
        evt.neg0        = fl_reg[0].neg;
        evt.neg1        = fl_reg[1].neg;
        evt.neg2        = fl_reg[2].neg;
        evt.whole       = whole_reg;
        evt.whole_neg   = wfl_reg.neg;
    end

    // Per byte state update
    always_comb
    begin
        logic clr_v;
        logic term_now;
        clr_v      = 1'b0;
        term_now   = term_reg || (c == 8'h00);
        hdr_next   = hdr_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        hlen_next  = hlen_reg;
        first_next = first_reg;
        term_next  = term_reg;
        fidx_next  = fidx_reg;
        acc_next   = acc_reg;
        fl_next    = fl_reg;
        whole_next = whole_reg;
        wfl_next   = wfl_reg;
        if (take)
        begin
            if (hdr_reg)
            begin
                if (c >= 8'd32 && c <= 8'd126)
                begin
                    if (c == ":")
                    begin
                        hdr_next = 1'b0;
                        clr_v    = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < NameCount; k++)
                        begin
                            if (pos_reg >= PosW'(name_len(k))
                                || name_char(k, 6'(pos_reg)) != c)
                            begin
                                match_next[k] = 1'b0;
                            end
                        end
                        pos_next  = pos_inc;
                        hlen_next = pos_inc;
                        if (pos_inc >= limit)
                        begin
                            pos_next   = '0;
                            match_next = '1;
                            hlen_next  = '0;
                        end
                    end
                end
            end
            else if (c == 8'h0A || c == 8'h0D)
            begin
                hdr_next   = 1'b1;
                pos_next   = '0;
                match_next = '1;
                hlen_next  = '0;
            end
            else
            begin
                if (pos_reg == '0)
                begin
                    first_next = c;
                end
                term_next = term_now;
                if (!term_now)
                begin
                    whole_next = whole_d;
                    wfl_next   = wfl_d;
                    if (c == ",")
                    begin
                        fl_next[fidx_reg].done = 1'b1;
                        if (fidx_reg < 2'd2)
                        begin
                            fidx_next = fidx_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        fl_next[fidx_reg]  = sel_fl_d;
                        acc_next[fidx_reg] = sel_acc_d;
                    end
                end
                pos_next = pos_inc;
                if (pos_inc >= limit)
                begin
                    clr_v = 1'b1;
                end
            end
        end
        if (clr_v)
        begin
            pos_next   = '0;
            first_next = '0;
            term_next  = 1'b0;
            fidx_next  = '0;
            whole_next = '0;
            wfl_next   = '0;
            for (int k = 0; k < 3; k++)
            begin
                acc_next[k] = '0;
                fl_next[k]  = '0;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg   <= 1'b1;
            pos_reg   <= '0;
            match_reg <= '1;
            hlen_reg  <= '0;
            first_reg <= '0;
            term_reg  <= 1'b0;
            fidx_reg  <= '0;
            whole_reg <= '0;
            wfl_reg   <= '0;
            for (int k = 0; k < 3; k++)
            begin
                acc_reg[k] <= '0;
                fl_reg[k]  <= '0;
            end
        end
        else
        begin
            hdr_reg   <= hdr_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            hlen_reg  <= hlen_next;
            first_reg <= first_next;
            term_reg  <= term_next;
            fidx_reg  <= fidx_next;
            whole_reg <= whole_next;
            wfl_reg   <= wfl_next;
            acc_reg   <= acc_next;
            fl_reg    <= fl_next;
        end
    end

endmodule

### design/hvlp_result.sv
module hvlp_result
    import hvlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  line_evt_t   evt,
    output logic        busy,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  msg_kind,
    output logic        flag_bit,
    output logic [31:0] gain_p,
    output logic [31:0] gain_i,
    output logic [31:0] gain_d,
    output logic [19:0] raw_reading,
    output logic [22:0] scaled_reading
);

    // Stage 1: decode and multiply; stage 2: divide by constant into the output register
    logic        s1_vld_reg;
    kind_t       s1_kind_reg;
    logic        s1_flag_reg;
    logic [31:0] s1_p_reg, s1_i_reg, s1_d_reg;
    logic [19:0] s1_raw_reg;
    logic [35:0] s1_num_reg;

    logic        o_vld_reg;
    logic [2:0]  o_kind_reg;
    logic        o_flag_reg;
    logic [31:0] o_p_reg, o_i_reg, o_d_reg;
    logic [19:0] o_raw_reg;
    logic [22:0] o_sc_reg;

    logic        hit;
    kind_t       kind;
    logic        keep;
    logic [19:0] raw;
    logic [35:0] num;
    logic [35:0] quo;
    logic        adv;

    logic [23:0] q_hi;
    logic [24:0] q_sum;
    logic [12:0] q_hi2;
    logic [13:0] q_rem;
    logic [26:0] q_n4;
    logic [54:0] q_prod;

    function automatic logic [31:0] to_signed(input logic [31:0] m, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = 32'(0) - m;
        end
        else
        begin
            r = m[31] ? 32'h7FFF_FFFF : m;
        end
        return r;
    endfunction

    // Match header by priority
    always_comb
    begin
        hit  = 1'b0;
        kind = KIND_NOK;
        for (int k = NameCount - 1; k >= 0; k--)
        begin
            if (evt.match[k] && evt.hlen == {3'b0, name_len(k)})
            begin
                hit  = 1'b1;
                kind = kind_t'(3'(k));
            end
        end
        keep = hit && !(kind == KIND_PID
                        && (evt.field_index < 2'd2 || evt.acc0 == 32'd0));
        raw  = evt.whole_neg ? 20'd0 : evt.whole[19:0];
        if (kind == KIND_POWER)
        begin
            num = 36'(raw) * 36'd25600 + 36'd2047;
        end
        else
        begin
            num = 36'(raw) * 36'd256 + 36'd50;
        end
    end

    // Quotient: power divides by 4095 by folding 12-bit chunks
    // (x = a*4096 + b = a*4095 + a + b), temperatures divide by 100 as
    // a quarter times the reciprocal of 25 scaled by 2^32
    always_comb
    begin
        q_hi   = s1_num_reg[35:12];
        q_sum  = 25'(q_hi) + 25'(s1_num_reg[11:0]);
        q_hi2  = q_sum[24:12];
        q_rem  = 14'(q_hi2) + 14'(q_sum[11:0]);
        q_n4   = s1_num_reg[28:2];
        q_prod = 55'(q_n4) * 55'(28'd171798692);
        if (s1_kind_reg == KIND_POWER)
        begin
            quo = 36'(q_hi) + 36'(q_hi2) + 36'(q_rem >= 14'd4095);
        end
        else
        begin
            quo = 36'(q_prod[54:32]);
        end
    end

    assign adv  = !o_vld_reg || out_ready;
    assign busy = s1_vld_reg && o_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                o_vld_reg <= s1_vld_reg;
            end
            if (adv || !s1_vld_reg)
            begin
                s1_vld_reg <= evt.fire && keep;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv || !s1_vld_reg)
        begin
            s1_kind_reg <= kind;
            s1_flag_reg <= (kind == KIND_MODE || kind == KIND_HEATER)
                           && evt.first_byte == "1";
            s1_p_reg    <= (kind == KIND_PID) ? to_signed(evt.acc0, evt.neg0) : '0;
            s1_i_reg    <= (kind == KIND_PID) ? to_signed(evt.acc1, evt.neg1) : '0;
            s1_d_reg    <= (kind == KIND_PID) ? to_signed(evt.acc2, evt.neg2) : '0;
            s1_raw_reg  <= raw;
            s1_num_reg  <= num;
        end
        if (adv)
        begin
            o_kind_reg <= s1_kind_reg;
            o_flag_reg <= s1_flag_reg;
            o_p_reg    <= s1_p_reg;
            o_i_reg    <= s1_i_reg;
            o_d_reg    <= s1_d_reg;
            if (s1_kind_reg == KIND_TEMP_C || s1_kind_reg == KIND_TEMP_A
                || s1_kind_reg == KIND_POWER)
            begin
                o_raw_reg <= s1_raw_reg;
                o_sc_reg  <= quo[22:0];
            end
            else
            begin
                o_raw_reg <= '0;
                o_sc_reg  <= '0;
            end
        end
    end

    assign out_valid      = o_vld_reg;
    assign msg_kind       = o_kind_reg;
    assign flag_bit       = o_flag_reg;
    assign gain_p         = o_p_reg;
    assign gain_i         = o_i_reg;
    assign gain_d         = o_d_reg;
    assign raw_reading    = o_raw_reg;
    assign scaled_reading = o_sc_reg;

endmodule
